>>> src/olng_pkg.sv
// Shared constants and codes for the ortho lattice neighbor generator.
package olng_pkg;

	localparam int DEF_MAX_DIMS  = 3;
	localparam int DEF_SITE_BITS = 16;
	localparam int REG_DIMS      = 3;
	localparam int EXT_W         = 8;
	localparam int SITE_W        = 16;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 8;
	localparam int DIV_BPS       = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_D0   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BOUNDARY_D0 = 3'd3;

	localparam logic signed [1:0] PH_NONE = 2'sb00;
	localparam logic signed [1:0] PH_POS  = 2'sb01;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_NONE  = 2'd1;
	localparam logic [1:0] STATUS_RANGE = 2'd2;

endpackage

>>> src/olng_div.sv
// Pipelined restoring divider: site-width dividend by an extent, a few bits per stage.
module olng_div import olng_pkg::*; #(
	parameter int SITE_BITS = DEF_SITE_BITS,
	parameter int TAG_W     = DEF_SITE_BITS + EXT_W * DEF_MAX_DIMS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [SITE_BITS-1:0] dividend,
	input  logic [EXT_W-1:0]     divisor,
	input  logic [TAG_W-1:0]     tag_i,
	output logic                 out_valid,
	output logic [SITE_BITS-1:0] quotient,
	output logic [EXT_W-1:0]     remainder,
	output logic [TAG_W-1:0]     tag_o
);

	localparam int NST = (SITE_BITS + DIV_BPS - 1) / DIV_BPS;

	logic                 v_s   [NST];
	logic [SITE_BITS-1:0] dq_s  [NST];
	logic [EXT_W-1:0]     rem_s [NST];
	logic [TAG_W-1:0]     tag_s [NST];

	for (genvar k = 0; k < NST; k++) begin : g_stage
		localparam int LEFT  = SITE_BITS - k * DIV_BPS;
		localparam int STEPS = (LEFT < DIV_BPS) ? LEFT : DIV_BPS;

		logic                 v_in;
		logic [SITE_BITS-1:0] dq_in, dq_w;
		logic [EXT_W-1:0]     rem_in, rem_w;
		logic [TAG_W-1:0]     tag_in;

		if (k == 0) begin : g_first
			assign v_in   = in_valid;
			assign dq_in  = dividend;
			assign rem_in = '0;
			assign tag_in = tag_i;
		end else begin : g_next
			assign v_in   = v_s[k-1];
			assign dq_in  = dq_s[k-1];
			assign rem_in = rem_s[k-1];
			assign tag_in = tag_s[k-1];
		end

		always_comb begin
			logic [EXT_W:0] r9;
			dq_w  = dq_in;
			rem_w = rem_in;
			for (int j = 0; j < STEPS; j++) begin
				r9   = {rem_w, dq_w[SITE_BITS-1]};
				dq_w = {dq_w[SITE_BITS-2:0], 1'b0};
				if (r9 >= {1'b0, divisor}) begin
					r9       = r9 - {1'b0, divisor};
					dq_w[0]  = 1'b1;
				end
				rem_w = r9[EXT_W-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dq_s[k]  <= dq_w;
				rem_s[k] <= rem_w;
				tag_s[k] <= tag_in;
			end
		end
	end

	assign out_valid = v_s[NST-1];
	assign quotient  = dq_s[NST-1];
	assign remainder = rem_s[NST-1];
	assign tag_o     = tag_s[NST-1];

endmodule

>>> src/ortho_lattice_neighbor_generator_core.sv
// Top level of the ortho lattice neighbor generator: config, unflatten pipeline, result sequencer.
// Pipeline: (MAX_DIMS-1)*ceil(SITE_BITS/4) divider stages, one candidate stage and one
//   sequencer stage.
// Flow: a site gives 1 to 2*MAX_DIMS results on the single result strobe, and the pipeline
//   holds the next site until the last of them leaves; results cannot be stalled by the receiver.
// Reset: extents 1, boundaries open; busy stays high after reset and after every config
//   write while the stride and wrap-span registers settle.
module ortho_lattice_neighbor_generator_core import olng_pkg::*; #(
	parameter int MAX_DIMS  = DEF_MAX_DIMS,
	parameter int SITE_BITS = DEF_SITE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [SITE_W-1:0]     site,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  result_valid,
	output logic [SITE_W-1:0]     neighbour_site,
	output logic signed [1:0]     phase,
	output logic [1:0]            dimension,
	output logic [1:0]            status,
	output logic                  last
);

	localparam int NSLOT    = 2 * MAX_DIMS;
	localparam int CRD_W    = EXT_W * MAX_DIMS;
	localparam int TAG_W    = SITE_BITS + CRD_W;
	localparam int SETTLE_N = MAX_DIMS + 1;
	localparam int SETTLE_W = $clog2(SETTLE_N + 1);
	localparam int L        = MAX_DIMS - 1;

	// ---------------------------------------------------------------- config
	// Dimensions past the register set keep extent 1 and an open boundary.
	logic [EXT_W-1:0]    ext_q    [MAX_DIMS];
	logic [1:0]          bnd_q    [MAX_DIMS];
	logic [SETTLE_W-1:0] settle_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < MAX_DIMS; d++) begin
				ext_q[d] <= EXT_W'(1);
				bnd_q[d] <= 2'b00;
			end
		end else if (cfg_valid) begin
			for (int d = 0; d < MAX_DIMS; d++) begin
				if (d < REG_DIMS && cfg_index == CFG_IDX_W'(CFG_EXTENT_D0 + d)) begin
					ext_q[d] <= cfg_data;
				end
				// boundary code normalized: 00 open, 01 periodic, 1x antiperiodic
				if (d < REG_DIMS && cfg_index == CFG_IDX_W'(CFG_BOUNDARY_D0 + d)) begin
					bnd_q[d] <= {cfg_data[1], cfg_data[1] | cfg_data[0]};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= SETTLE_W'(SETTLE_N);
		end else if (cfg_valid) begin
			settle_q <= SETTLE_W'(SETTLE_N);
		end else if (settle_q != '0) begin
			settle_q <= settle_q - 1'b1;
		end
	end

	// Stride of dim d is the product of the faster extents; span is (extent-1)*stride,
	// the jump of a boundary wrap. One multiply per register, rippling from the fastest dim down.
	logic [SITE_BITS-1:0] stride_q [MAX_DIMS];
	logic [SITE_BITS-1:0] span_q   [MAX_DIMS];

	for (genvar d = 0; d < MAX_DIMS; d++) begin : g_stride
		if (d == MAX_DIMS - 1) begin : g_fast
			always_ff @(posedge clk) stride_q[d] <= SITE_BITS'(1);
		end else begin : g_slow
			always_ff @(posedge clk) stride_q[d] <= SITE_BITS'(stride_q[d+1] * ext_q[d+1]);
		end
		always_ff @(posedge clk) span_q[d] <= SITE_BITS'(stride_q[d] * (ext_q[d] - 1'b1));
	end

	// ---------------------------------------------------------------- pipeline control
	logic adv;
	assign busy = !adv || (settle_q != '0);

	// ---------------------------------------------------------------- unflatten chain
	// One divider per dimension from the fastest down to dim 1; the quotient left at the
	// end is the dim 0 coordinate. Coordinates ride in the tag next to the site.
	logic                 link_v   [MAX_DIMS];
	logic [SITE_BITS-1:0] link_q   [MAX_DIMS];
	logic [TAG_W-1:0]     link_tag [MAX_DIMS];
	logic [SITE_BITS-1:0] site_m;

	assign site_m      = SITE_BITS'(site);
	assign link_v[0]   = start && !busy;
	assign link_q[0]   = site_m;
	assign link_tag[0] = {site_m, CRD_W'(0)};

	for (genvar k = 0; k < MAX_DIMS - 1; k++) begin : g_div
		localparam int D = MAX_DIMS - 1 - k;
		logic [EXT_W-1:0] rem;
		logic [TAG_W-1:0] tag_o;

		olng_div #(
			.SITE_BITS (SITE_BITS),
			.TAG_W     (TAG_W)
		) u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (adv),
			.in_valid  (link_v[k]),
			.dividend  (link_q[k]),
			.divisor   (ext_q[D]),
			.tag_i     (link_tag[k]),
			.out_valid (link_v[k+1]),
			.quotient  (link_q[k+1]),
			.remainder (rem),
			.tag_o     (tag_o)
		);

		assign link_tag[k+1] = tag_o | (TAG_W'(rem) << (EXT_W * D));
	end

	// ---------------------------------------------------------------- candidates
	// Two slots per dimension, in emission order; each slot has its own valid bit.
	logic [SITE_BITS-1:0] fin_site;
	logic [SITE_BITS-1:0] c0;
	logic [NSLOT-1:0]     mask_c;
	logic [SITE_BITS-1:0] nb_c [NSLOT];
	logic signed [1:0]    ph_c [NSLOT];
	logic [1:0]           sts_c;
	logic                 out_rng;

	assign fin_site = link_tag[L][CRD_W +: SITE_BITS];
	assign c0       = link_q[L];

	always_comb begin
		logic [EXT_W-1:0]     e, mx, c;
		logic [SITE_BITS-1:0] p_pos, p_neg, w_pos, w_neg;
		logic signed [1:0]    bc;
		out_rng = (32'(c0) >= 32'(ext_q[0]));
		for (int d = 0; d < MAX_DIMS; d++) begin
			if (ext_q[d] == '0) out_rng = 1'b1;
		end
		for (int d = 0; d < MAX_DIMS; d++) begin
			e     = ext_q[d];
			mx    = e - 1'b1;
			c     = (d == 0) ? EXT_W'(c0) : link_tag[L][EXT_W*d +: EXT_W];
			p_pos = fin_site + stride_q[d];
			p_neg = fin_site - stride_q[d];
			w_pos = fin_site + span_q[d];
			w_neg = fin_site - span_q[d];
			bc    = bnd_q[d];
			mask_c[2*d]   = 1'b0;
			mask_c[2*d+1] = 1'b0;
			nb_c[2*d]     = p_neg;
			nb_c[2*d+1]   = p_pos;
			ph_c[2*d]     = PH_POS;
			ph_c[2*d+1]   = PH_POS;
			if (e <= EXT_W'(1)) begin
				// single site along this dimension: no bonds
			end else if (e == EXT_W'(2)) begin
				mask_c[2*d] = 1'b1;
				nb_c[2*d]   = (c == '0) ? p_pos : p_neg;
			end else if (c == '0) begin
				mask_c[2*d]   = (bc != PH_NONE);
				nb_c[2*d]     = w_pos;
				ph_c[2*d]     = bc;
				mask_c[2*d+1] = 1'b1;
			end else if (c == mx) begin
				mask_c[2*d]   = 1'b1;
				mask_c[2*d+1] = (bc != PH_NONE);
				nb_c[2*d+1]   = w_neg;
				ph_c[2*d+1]   = bc;
			end else begin
				mask_c[2*d]   = 1'b1;
				mask_c[2*d+1] = 1'b1;
			end
		end
		// status items take slot 0 alone with zeroed payload
		if (out_rng) begin
			sts_c = STATUS_RANGE;
		end else if (mask_c == '0) begin
			sts_c = STATUS_NONE;
		end else begin
			sts_c = STATUS_OK;
		end
		if (sts_c != STATUS_OK) begin
			mask_c  = NSLOT'(1);
			nb_c[0] = '0;
			ph_c[0] = PH_NONE;
		end
	end

	logic                 v_s1;
	logic [NSLOT-1:0]     mask_s1;
	logic [SITE_BITS-1:0] nb_s1 [NSLOT];
	logic signed [1:0]    ph_s1 [NSLOT];
	logic [1:0]           sts_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= link_v[L];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mask_s1 <= mask_c;
			nb_s1   <= nb_c;
			ph_s1   <= ph_c;
			sts_s1  <= sts_c;
		end
	end

	// ---------------------------------------------------------------- result sequencer
	// Emits the lowest pending slot each cycle; the next site loads as the last one leaves.
	logic [NSLOT-1:0]     mask_q;
	logic [SITE_BITS-1:0] nb_q [NSLOT];
	logic signed [1:0]    ph_q [NSLOT];
	logic [1:0]           sts_q;
	logic [NSLOT-1:0]     sel;
	logic [NSLOT-1:0]     mask_nxt;
	logic                 load;

	always_comb begin
		logic found;
		found = 1'b0;
		sel   = '0;
		for (int i = 0; i < NSLOT; i++) begin
			if (mask_q[i] && !found) begin
				sel[i] = 1'b1;
				found  = 1'b1;
			end
		end
	end

	assign mask_nxt = mask_q & ~sel;
	assign load     = v_s1 && (mask_nxt == '0);
	assign adv      = !(v_s1 && (mask_nxt != '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (load) begin
			mask_q <= mask_s1;
		end else begin
			mask_q <= mask_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			nb_q  <= nb_s1;
			ph_q  <= ph_s1;
			sts_q <= sts_s1;
		end
	end

	always_comb begin
		logic [SITE_BITS-1:0] nb_sel;
		nb_sel    = '0;
		phase     = PH_NONE;
		dimension = '0;
		for (int i = 0; i < NSLOT; i++) begin
			if (sel[i]) begin
				nb_sel    = nb_q[i];
				phase     = ph_q[i];
				dimension = 2'(i / 2);
			end
		end
		neighbour_site = SITE_W'(nb_sel);
	end

	assign result_valid = (mask_q != '0);
	assign status       = sts_q;
	assign last         = (mask_nxt == '0);

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the ortho lattice neighbor generator core.
module testbench;
	import olng_pkg::*;

	// one neighbor result as the block presents it
	typedef struct packed {
		logic [SITE_W-1:0] nb;
		logic signed [1:0] ph;
		logic [1:0]        dim;
		logic [1:0]        st;
		logic              lst;
	} nbr_t;

	// neighbor list predictor plus queue of pending neighbor results
	class nbr_scoreboard;
		int unsigned ext[3];
		logic signed [1:0] bnd[3];
		nbr_t pending[$];
		int errors;
		int shown;

		function void set_reg(int idx, logic [CFG_DATA_W-1:0] v);
			if (idx < REG_DIMS)
				ext[idx] = 32'(v);
			else if (idx < 2 * REG_DIMS)
				bnd[idx - REG_DIMS] = (v[1:0] == 2'b00) ? PH_NONE :
					(v[1] ? -2'sd1 : PH_POS);
		endfunction

		function void push(int unsigned nb, logic signed [1:0] ph, int d, logic [1:0] st);
			nbr_t r;
			r.nb = nb[SITE_W-1:0];
			r.ph = ph;
			r.dim = d[1:0];
			r.st = st;
			r.lst = 1'b0;
			pending.push_back(r);
		endfunction

		// work out the neighbor list of one accepted site
		function void note_site(logic [SITE_W-1:0] s);
			int unsigned total, rem, str, c, mx, base;
			int unsigned crd[3], stride[3];
			int n0, d;
			nbr_t r;
			total = ext[0] * ext[1] * ext[2];
			n0 = pending.size();
			if (32'(s) >= total) begin
				push(0, PH_NONE, 0, STATUS_RANGE);
			end else begin
				rem = 32'(s);
				str = 1;
				for (d = 2; d >= 0; d--) begin
					stride[d] = str;
					crd[d] = rem % ext[d];
					rem = rem / ext[d];
					str = str * ext[d];
				end
				for (d = 0; d < 3; d++) begin
					c = crd[d];
					mx = ext[d] - 1;
					base = 32'(s) - c * stride[d];
					if (mx == 0) continue;
					if (mx == 1) begin
						push(base + (c ^ 1) * stride[d], PH_POS, d, STATUS_OK);
					end else if (c == 0) begin
						if (bnd[d] != 0) push(base + mx * stride[d], bnd[d], d, STATUS_OK);
						push(base + stride[d], PH_POS, d, STATUS_OK);
					end else if (c == mx) begin
						push(base + (mx - 1) * stride[d], PH_POS, d, STATUS_OK);
						if (bnd[d] != 0) push(base, bnd[d], d, STATUS_OK);
					end else begin
						push(base + (c - 1) * stride[d], PH_POS, d, STATUS_OK);
						push(base + (c + 1) * stride[d], PH_POS, d, STATUS_OK);
					end
				end
				if (pending.size() == n0) push(0, PH_NONE, 0, STATUS_NONE);
			end
			r = pending[$];
			r.lst = 1'b1;
			pending[$] = r;
		endfunction

		function void check_result(nbr_t got);
			nbr_t want;
			if (pending.size() == 0) begin
				errors++;
				if (shown < 10) begin
					shown++;
					$display("unexpected result nb=%0d ph=%0d dim=%0d st=%0d last=%0b",
						got.nb, got.ph, got.dim, got.st, got.lst);
				end
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				errors++;
				if (shown < 10) begin
					shown++;
					$display("mismatch exp nb=%0d ph=%0d dim=%0d st=%0d last=%0b",
						want.nb, want.ph, want.dim, want.st, want.lst);
					$display("         got nb=%0d ph=%0d dim=%0d st=%0d last=%0b",
						got.nb, got.ph, got.dim, got.st, got.lst);
				end
			end
		endfunction
	endclass

	localparam int WATCHDOG = 20000;
	localparam int DRAIN    = 40;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [SITE_W-1:0]     site;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  result_valid;
	logic [SITE_W-1:0]     neighbour_site;
	logic signed [1:0]     phase;
	logic [1:0]            dimension;
	logic [1:0]            status;
	logic                  last;

	nbr_scoreboard sb;
	int idle_cycles;
	int burst_left;

	ortho_lattice_neighbor_generator_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .site(site),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .result_valid(result_valid),
		.neighbour_site(neighbour_site), .phase(phase), .dimension(dimension),
		.status(status), .last(last)
	);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	// results cannot be held off: every strobe goes straight to the checker
	always @(posedge clk) begin
		if (arst_n && result_valid)
			sb.check_result({neighbour_site, phase, dimension, status, last});
	end

	// watchdog on cycles with no handshake of any kind
	always @(posedge clk) begin
		if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// wait until every predicted result has come, plus pipeline tail
	task automatic drain();
		start <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	// config write; only called with the block idle, valid dropped by the caller
	task automatic write_reg(int idx, logic [CFG_DATA_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx[CFG_IDX_W-1:0];
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(idx, v);
	endtask

	task automatic set_lattice(int e0, int e1, int e2, int b0, int b1, int b2);
		drain();
		write_reg(int'(CFG_EXTENT_D0), CFG_DATA_W'(e0));
		write_reg(int'(CFG_EXTENT_D0) + 1, CFG_DATA_W'(e1));
		write_reg(int'(CFG_EXTENT_D0) + 2, CFG_DATA_W'(e2));
		write_reg(int'(CFG_BOUNDARY_D0), CFG_DATA_W'(b0));
		write_reg(int'(CFG_BOUNDARY_D0) + 1, CFG_DATA_W'(b1));
		write_reg(int'(CFG_BOUNDARY_D0) + 2, CFG_DATA_W'(b2));
		cfg_valid <= 1'b0;
	endtask

	// one site; when gaps is set the sender works in bursts with random idle gaps in between
	task automatic send_site(logic [SITE_W-1:0] s, bit gaps);
		int gap;
		if (gaps) begin
			if (burst_left == 0) begin
				gap = $urandom_range(0, 12);
				if (gap != 0) begin
					start <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst_left = $urandom_range(1, 10);
			end
			burst_left--;
		end
		start <= 1'b1;
		site  <= s;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_site(s);
	endtask

	// random site: mostly in range, sometimes just past the end, sometimes any value
	function automatic logic [SITE_W-1:0] pick_site();
		int unsigned total;
		int k;
		total = sb.ext[0] * sb.ext[1] * sb.ext[2];
		k = $urandom_range(0, 9);
		if (k == 0 || total == 0) return SITE_W'($urandom());
		if (k == 1) return SITE_W'(total + $urandom_range(0, 3));
		if (total > 65536) return SITE_W'($urandom());
		return SITE_W'($urandom_range(0, total - 1));
	endfunction

	function automatic int pick_bnd();
		return $urandom_range(0, 3);
	endfunction

	initial begin
		int i, p;
		sb = new();
		sb.ext = '{1, 1, 1};
		sb.bnd = '{PH_NONE, PH_NONE, PH_NONE};
		idle_cycles = 0;
		burst_left = 0;
		arst_n = 1'b0;
		start = 1'b0;
		site = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset lattice: one site, no neighbors, all else out of range
		send_site(16'd0, 0);
		send_site(16'd1, 0);
		send_site(16'hFFFF, 0);

		// 4x3x5, periodic / antiperiodic / open; corners, interior and one site past the end
		set_lattice(4, 3, 5, 1, 3, 0);
		send_site(16'd0, 0);
		send_site(16'd59, 0);
		send_site(16'd22, 0);
		send_site(16'd60, 0);
		// extent two along each dim, boundary pattern 10 treated as antiperiodic
		set_lattice(2, 2, 2, 2, 1, 3);
		send_site(16'd0, 0);
		send_site(16'd7, 0);
		// largest extents: wrapping neighbor index, full site range
		set_lattice(255, 255, 255, 1, 1, 1);
		send_site(16'd0, 0);
		send_site(16'hFFFF, 0);
		send_site(16'hAAAA, 0);
		send_site(16'h5555, 0);
		// extent zero: everything out of range
		set_lattice(0, 7, 7, 0, 0, 0);
		send_site(16'd0, 0);
		send_site(16'd3, 0);

		for (p = 0; p < 12; p++) begin
			case (p % 4)
				0: set_lattice($urandom_range(1, 8), $urandom_range(1, 8),
					$urandom_range(1, 8), pick_bnd(), pick_bnd(), pick_bnd());
				1: set_lattice($urandom_range(1, 3), $urandom_range(1, 40),
					$urandom_range(1, 255), pick_bnd(), pick_bnd(), pick_bnd());
				2: set_lattice($urandom_range(0, 255), $urandom_range(0, 255),
					$urandom_range(0, 255), pick_bnd(), pick_bnd(), pick_bnd());
				default: set_lattice(1, $urandom_range(1, 2), $urandom_range(1, 255),
					pick_bnd(), pick_bnd(), pick_bnd());
			endcase
			for (i = 0; i < 30; i++) begin
				// hold back once per phase until everything has drained
				if (i == 15) drain();
				send_site(pick_site(), p != 5);
			end
		end

		drain();
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
